FILE: rtl/dic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dic_pkg: shared types and constants of the discrete input conditioner
// Register indexes, control flag bit positions, edge modes and the
// configuration bundle handed from the register file to the datapath.
// ----------------------------------------------------------------------------
package dic_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_CONTROL_FLAGS = 3'd0,
        REG_EDGE_MODE     = 3'd1,
        REG_DEBOUNCE      = 3'd2,
        REG_ON_DELAY      = 3'd3,
        REG_OFF_DELAY     = 3'd4,
        REG_LOW_LIMIT     = 3'd5,
        REG_HIGH_LIMIT    = 3'd6
    } reg_index_t;

    // control flag bit positions
    localparam int unsigned FLAG_INVERT      = 0;
    localparam int unsigned FLAG_THRESHOLD   = 1;
    localparam int unsigned FLAG_THR_INVERT  = 2;
    localparam int unsigned FLAG_DEP_LEVEL   = 3;

    localparam int unsigned CTRL_W     = 4;
    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned ANALOG_W   = 32;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 3;

    // edge handling after the timers
    typedef enum logic [1:0] {
        EDGE_PASS = 2'd0,
        EDGE_RISE = 2'd1,
        EDGE_FALL = 2'd2
    } edge_mode_t;

    // configuration bundle
    typedef struct packed {
        logic [CTRL_W-1:0]     control_flags;
        edge_mode_t            edge_mode;
        logic [INTERVAL_W-1:0] debounce_ticks;
        logic [INTERVAL_W-1:0] on_delay_ticks;
        logic [INTERVAL_W-1:0] off_delay_ticks;
        logic [ANALOG_W-1:0]   low_limit;
        logic [ANALOG_W-1:0]   high_limit;
    } cfg_t;

endpackage

FILE: rtl/dic_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dic_cfg_regs: configuration register file
// Write-only registers selected by index, cleared to zero at reset.
// ----------------------------------------------------------------------------
module dic_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dic_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dic_pkg::CFG_DATA_W-1:0]  cfg_data,
    output dic_pkg::cfg_t                   cfg
);

    dic_pkg::cfg_t cfg_reg;
    dic_pkg::cfg_t cfg_next;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (dic_pkg::reg_index_t'(cfg_index))
                dic_pkg::REG_CONTROL_FLAGS:
                    cfg_next.control_flags = cfg_data[dic_pkg::CTRL_W-1:0];
                dic_pkg::REG_EDGE_MODE:
                    cfg_next.edge_mode = dic_pkg::edge_mode_t'(cfg_data[1:0]);
                dic_pkg::REG_DEBOUNCE:
                    cfg_next.debounce_ticks = cfg_data[dic_pkg::INTERVAL_W-1:0];
                dic_pkg::REG_ON_DELAY:
                    cfg_next.on_delay_ticks = cfg_data[dic_pkg::INTERVAL_W-1:0];
                dic_pkg::REG_OFF_DELAY:
                    cfg_next.off_delay_ticks = cfg_data[dic_pkg::INTERVAL_W-1:0];
                dic_pkg::REG_LOW_LIMIT:
                    cfg_next.low_limit = cfg_data[dic_pkg::ANALOG_W-1:0];
                dic_pkg::REG_HIGH_LIMIT:
                    cfg_next.high_limit = cfg_data[dic_pkg::ANALOG_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/dic_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dic_delay: one on-delay or off-delay timer step
// Combinational next state of a delay stage. The active level is the level
// that is held back until the timer expires; the other level passes at once.
// ----------------------------------------------------------------------------
module dic_delay
#(
    parameter int unsigned TIMER_BITS = 16
)
(
    input  logic                              active,
    input  logic                              din,
    input  logic                              prev,
    input  logic                              level,
    input  logic [TIMER_BITS-1:0]             count,
    input  logic [dic_pkg::INTERVAL_W-1:0]    interval,
    output logic                              level_next,
    output logic                              prev_next,
    output logic [TIMER_BITS-1:0]             count_next
);

    localparam int unsigned CMP_W =
        (TIMER_BITS > dic_pkg::INTERVAL_W) ? TIMER_BITS : dic_pkg::INTERVAL_W;
    localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

    logic                  bypass;
    logic                  restart;
    logic [TIMER_BITS-1:0] count_inc;
    logic                  expired;

    // saturating tick, restart on an edge into the active level
    assign bypass    = (interval == '0);
    assign count_inc = (count == CNT_MAX) ? count : count + 1'b1;
    assign restart   = !bypass && (din == active) && (prev != active);
    assign count_next = restart ? '0 : count_inc;

    // interval clamps to the counter maximum
    assign expired = (count_next == CNT_MAX) ||
                     (CMP_W'(count_next) >= CMP_W'(interval));

    // level and edge memory update
    always_comb
    begin
        if (bypass)
        begin
            level_next = din;
            prev_next  = prev;
        end
        else
        begin
            prev_next  = din;
            level_next = ((din != active) || expired) ? din : level;
        end
    end

endmodule

FILE: rtl/dic_cond.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dic_cond: conditioning datapath and its state
// Level source, dependency override, debounce, on/off delays and edge
// toggle for one item, with the state registers updated on each step.
// ----------------------------------------------------------------------------
module dic_cond
#(
    parameter int unsigned TIMER_BITS = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  dic_pkg::cfg_t                    cfg,
    input  logic                             step_en,
    input  logic                             sample_bit,
    input  logic [dic_pkg::ANALOG_W-1:0]     analog_value,
    input  logic                             dep_ok,
    input  logic                             force_req,
    output logic                             level,
    output logic                             publish
);

    localparam int unsigned CMP_W =
        (TIMER_BITS > dic_pkg::INTERVAL_W) ? TIMER_BITS : dic_pkg::INTERVAL_W;
    localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

    // state registers
    logic                  out_level_reg,  out_level_next;
    logic                  deb_pause_reg,  deb_pause_next;
    logic                  deb_level_reg,  deb_level_next;
    logic                  deb_prev_reg,   deb_prev_next;
    logic [TIMER_BITS-1:0] deb_count_reg,  deb_count_next;
    logic                  on_level_reg,   on_level_next;
    logic                  on_prev_reg,    on_prev_next;
    logic [TIMER_BITS-1:0] on_count_reg,   on_count_next;
    logic                  off_level_reg,  off_level_next;
    logic                  off_prev_reg,   off_prev_next;
    logic [TIMER_BITS-1:0] off_count_reg,  off_count_next;
    logic                  edge_prev_reg,  edge_prev_next;
    logic                  edge_level_reg, edge_level_next;

    logic                  src_level;
    logic                  cond_level;
    logic                  deb_change;
    logic                  deb_start;
    logic                  deb_pause_mid;
    logic                  deb_expired;
    logic [TIMER_BITS-1:0] deb_count_inc;
    logic                  timed_level;
    logic                  result_level;

    // rising path: on-delay then off-delay
    logic                  on_a_level, on_a_prev;
    logic [TIMER_BITS-1:0] on_a_count;
    logic                  off_a_level, off_a_prev;
    logic [TIMER_BITS-1:0] off_a_count;
    // falling path: off-delay then on-delay
    logic                  off_b_level, off_b_prev;
    logic [TIMER_BITS-1:0] off_b_count;
    logic                  on_b_level, on_b_prev;
    logic [TIMER_BITS-1:0] on_b_count;

    // level source: digital bit or analog hysteresis band
    always_comb
    begin
        src_level = sample_bit;
        if (cfg.control_flags[dic_pkg::FLAG_THRESHOLD])
        begin
            priority if ($signed(analog_value) <= $signed(cfg.low_limit))
                src_level = cfg.control_flags[dic_pkg::FLAG_THR_INVERT];
            else if ($signed(analog_value) >= $signed(cfg.high_limit))
                src_level = !cfg.control_flags[dic_pkg::FLAG_THR_INVERT];
            else
                src_level = out_level_reg;
        end
    end

    // dependency override and invert
    assign cond_level = !dep_ok ? cfg.control_flags[dic_pkg::FLAG_DEP_LEVEL] :
                        (src_level ^ cfg.control_flags[dic_pkg::FLAG_INVERT]);

    // debounce: a change opens a pause, the level latches when it expires
    assign deb_count_inc = (deb_count_reg == CNT_MAX) ? deb_count_reg
                                                       : deb_count_reg + 1'b1;
    assign deb_change    = (cond_level != deb_prev_reg);
    assign deb_start     = deb_change && !deb_pause_reg;
    assign deb_pause_mid = deb_pause_reg || deb_start;

    always_comb
    begin
        deb_prev_next  = deb_prev_reg;
        deb_pause_next = deb_pause_reg;
        deb_level_next = cond_level;
        deb_count_next = deb_count_inc;
        deb_expired    = 1'b0;
        if (cfg.debounce_ticks != '0)
        begin
            deb_prev_next  = cond_level;
            deb_count_next = deb_start ? '0 : deb_count_inc;
            deb_expired    = (deb_count_next == CNT_MAX) ||
                             (CMP_W'(deb_count_next) >= CMP_W'(cfg.debounce_ticks));
            if (deb_pause_mid && deb_expired)
            begin
                deb_level_next = cond_level;
                deb_pause_next = 1'b0;
            end
            else
            begin
                deb_level_next = deb_level_reg;
                deb_pause_next = deb_pause_mid;
            end
        end
    end

    // timers, both orders evaluated, picked by the debounced level
    dic_delay #(.TIMER_BITS(TIMER_BITS)) u_on_a
    (
        .active     (1'b1),
        .din        (1'b1),
        .prev       (on_prev_reg),
        .level      (on_level_reg),
        .count      (on_count_reg),
        .interval   (cfg.on_delay_ticks),
        .level_next (on_a_level),
        .prev_next  (on_a_prev),
        .count_next (on_a_count)
    );

    dic_delay #(.TIMER_BITS(TIMER_BITS)) u_off_a
    (
        .active     (1'b0),
        .din        (on_a_level),
        .prev       (off_prev_reg),
        .level      (off_level_reg),
        .count      (off_count_reg),
        .interval   (cfg.off_delay_ticks),
        .level_next (off_a_level),
        .prev_next  (off_a_prev),
        .count_next (off_a_count)
    );

    dic_delay #(.TIMER_BITS(TIMER_BITS)) u_off_b
    (
        .active     (1'b0),
        .din        (1'b0),
        .prev       (off_prev_reg),
        .level      (off_level_reg),
        .count      (off_count_reg),
        .interval   (cfg.off_delay_ticks),
        .level_next (off_b_level),
        .prev_next  (off_b_prev),
        .count_next (off_b_count)
    );

    dic_delay #(.TIMER_BITS(TIMER_BITS)) u_on_b
    (
        .active     (1'b1),
        .din        (off_b_level),
        .prev       (on_prev_reg),
        .level      (on_level_reg),
        .count      (on_count_reg),
        .interval   (cfg.on_delay_ticks),
        .level_next (on_b_level),
        .prev_next  (on_b_prev),
        .count_next (on_b_count)
    );

    always_comb
    begin
        if (deb_level_next)
        begin
            on_level_next  = on_a_level;
            on_prev_next   = on_a_prev;
            on_count_next  = on_a_count;
            off_level_next = off_a_level;
            off_prev_next  = off_a_prev;
            off_count_next = off_a_count;
            timed_level    = off_a_level;
        end
        else
        begin
            on_level_next  = on_b_level;
            on_prev_next   = on_b_prev;
            on_count_next  = on_b_count;
            off_level_next = off_b_level;
            off_prev_next  = off_b_prev;
            off_count_next = off_b_count;
            timed_level    = on_b_level;
        end
    end

    // edge toggle
    always_comb
    begin
        edge_prev_next  = edge_prev_reg;
        edge_level_next = edge_level_reg;
        result_level    = timed_level;
        unique case (cfg.edge_mode)
            dic_pkg::EDGE_RISE:
            begin
                edge_level_next = edge_level_reg ^ (timed_level && !edge_prev_reg);
                edge_prev_next  = timed_level;
                result_level    = edge_level_next;
            end
            dic_pkg::EDGE_FALL:
            begin
                edge_level_next = edge_level_reg ^ (!timed_level && edge_prev_reg);
                edge_prev_next  = timed_level;
                result_level    = edge_level_next;
            end
            default:
            begin
                result_level = timed_level;
            end
        endcase
    end

    // result
    assign out_level_next = result_level;
    assign level          = result_level;
    assign publish        = force_req || (result_level != out_level_reg);

    // state update, one step per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_level_reg  <= 1'b0;
            deb_pause_reg  <= 1'b0;
            deb_level_reg  <= 1'b0;
            deb_prev_reg   <= 1'b0;
            deb_count_reg  <= '0;
            on_level_reg   <= 1'b0;
            on_prev_reg    <= 1'b0;
            on_count_reg   <= '0;
            off_level_reg  <= 1'b0;
            off_prev_reg   <= 1'b0;
            off_count_reg  <= '0;
            edge_prev_reg  <= 1'b0;
            edge_level_reg <= 1'b0;
        end
        else if (step_en)
        begin
            out_level_reg  <= out_level_next;
            deb_pause_reg  <= deb_pause_next;
            deb_level_reg  <= deb_level_next;
            deb_prev_reg   <= deb_prev_next;
            deb_count_reg  <= deb_count_next;
            on_level_reg   <= on_level_next;
            on_prev_reg    <= on_prev_next;
            on_count_reg   <= on_count_next;
            off_level_reg  <= off_level_next;
            off_prev_reg   <= off_prev_next;
            off_count_reg  <= off_count_next;
            edge_prev_reg  <= edge_prev_next;
            edge_level_reg <= edge_level_next;
        end
    end

endmodule

FILE: rtl/discrete_input_conditioner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// discrete_input_conditioner_unit: debounced, delayed discrete input
// Top level with stream ports, configuration port and the two pipeline
// registers around the conditioning datapath.
// ----------------------------------------------------------------------------
// Each accepted item is one sample tick and yields exactly one result item.
// The block takes one item per clock while the result side keeps taking
// items: an input register feeds the conditioning logic, which updates its
// state and loads the result register in the same cycle once the result
// register is free or draining. Each item passes through the input register
// and then the result register; a stall on the result side holds it in the
// input register. All timers are TIMER_BITS wide and saturate; the user must
// write configuration registers through the cfg port only while no item is
// in flight, which the block itself does not enforce.
module discrete_input_conditioner_unit
#(
    parameter int unsigned TIMER_BITS = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_we,
    input  logic [dic_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dic_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [39:0]                      s_tdata,  // sample_bit, analog_value, dep_ok, force_req
    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata   // level, publish
);

    dic_pkg::cfg_t cfg;

    logic                          in_valid_reg, in_valid_next;
    logic                          sample_bit_reg;
    logic [dic_pkg::ANALOG_W-1:0]  analog_value_reg;
    logic                          dep_ok_reg;
    logic                          force_req_reg;

    logic                          out_valid_reg, out_valid_next;
    logic                          level_reg;
    logic                          publish_reg;

    logic                          step_en;
    logic                          in_take;
    logic                          level;
    logic                          publish;

    dic_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // handshake: the step runs when the result register is free or draining
    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;
    assign in_take  = s_tvalid && s_tready;

    assign in_valid_next  = in_take || (in_valid_reg && !step_en);
    assign out_valid_next = step_en || (out_valid_reg && !m_tready);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_bit_reg   <= s_tdata[0];
            analog_value_reg <= s_tdata[32:1];
            dep_ok_reg       <= s_tdata[33];
            force_req_reg    <= s_tdata[34];
        end
    end

    dic_cond #(.TIMER_BITS(TIMER_BITS)) u_cond
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .step_en      (step_en),
        .sample_bit   (sample_bit_reg),
        .analog_value (analog_value_reg),
        .dep_ok       (dep_ok_reg),
        .force_req    (force_req_reg),
        .level        (level),
        .publish      (publish)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            level_reg   <= level;
            publish_reg <= publish;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, publish_reg, level_reg};

endmodule
